>>> src/hashed_sample_count_table_defines.svh
// assertion macros shared by the checker
`ifndef HASHED_SAMPLE_COUNT_TABLE_DEFINES_SVH
`define HASHED_SAMPLE_COUNT_TABLE_DEFINES_SVH

// same-cycle implication
`define HSCT_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSCT_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/hsct_pkg.sv
package hsct_pkg;

    typedef logic [11:0] t_index;
    typedef logic [12:0] t_used;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [2:0] ST_INSERTED    = 3'd0;
    localparam logic [2:0] ST_ACCUMULATED = 3'd1;
    localparam logic [2:0] ST_DROPPED     = 3'd2;
    localparam logic [2:0] ST_CLEARED     = 3'd3;
    localparam logic [2:0] ST_READ        = 3'd4;
    localparam logic [2:0] ST_INVALID     = 3'd5;

    localparam logic [31:0] MIX_MUL_A    = 32'h7feb352d;
    localparam logic [31:0] MIX_MUL_B    = 32'h846ca68b;
    localparam logic [31:0] HASH_OFF_MUL = 32'h9e3779b1;
    localparam logic [31:0] HASH_THR_MUL = 32'h85ebca77;

    localparam int KEY_W   = 64;
    localparam int COUNT_W = 32;
    localparam int ENTRY_W = KEY_W + COUNT_W;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] code_offset;
        logic [15:0] module_tag;
        logic [15:0] thread_tag;
        logic [31:0] add_count;
        t_index      read_index;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        t_index      entry_index;
        logic        entry_valid;
        logic [31:0] entry_offset;
        logic [15:0] entry_module;
        logic [15:0] entry_thread;
        logic [31:0] entry_count;
        t_used       used_entries;
        logic [63:0] dropped_total;
    } t_result;

endpackage

>>> src/hsct_ram.sv
module hsct_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/hashed_sample_count_table.sv
// Counting hash table, one item at a time. After reset the table is swept empty,
// one entry per cycle with busy high; a clear item does the same sweep and
// reports at its end. An add holds busy while it probes 1 to MAX_PROBES
// entries: three registered hash stages, then the entries are read in turn
// from the single table memory. A read item holds busy for one cycle. The
// result of a clear, an add or a read comes with o_done in the same cycle that
// busy falls. An add with thread tag zero or an unused action answers in the
// cycle after it is taken and leaves busy low. Each result is shown for one
// cycle with o_done and cannot be held off.
module hashed_sample_count_table #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_PROBES    = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  hsct_pkg::t_cmd    i_cmd,
    output logic              o_done,
    output hsct_pkg::t_result o_result
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int PROBE_W = $clog2(MAX_PROBES + 1);
    localparam int USED_W  = IDX_W + 1;

    typedef logic [IDX_W-1:0]   t_tidx;
    typedef logic [PROBE_W-1:0] t_probe;
    typedef logic [USED_W-1:0]  t_cnt;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_H1   = 7'b0000010,
        S_H2   = 7'b0000100,
        S_H3   = 7'b0001000,
        S_CMP  = 7'b0010000,
        S_RDX  = 7'b0100000,
        S_CLR  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    t_tidx             r_idx;
    t_probe            r_probe;
    t_cnt              r_used;
    logic [63:0]       r_lost;
    logic              r_clr_report;
    logic [31:0]       r_a, r_c, r_v;
    logic [63:0]       r_key;
    logic [31:0]       r_n;
    logic              r_done, n_done;
    hsct_pkg::t_result r_res, n_res;

    logic                        ram_we;
    t_tidx                       ram_waddr, ram_raddr;
    logic [hsct_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic [63:0] rd_key;
    logic [31:0] rd_count, acc_count;
    logic [31:0] mix0, mix1, mix2, mix3;
    t_tidx       hash_idx;
    logic        rd_empty, rd_match, probe_last, accept;

    hsct_ram #(
        .WIDTH (hsct_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept     = start && (r_state == S_IDLE);
    assign rd_key     = ram_rdata[hsct_pkg::KEY_W-1:0];
    assign rd_count   = ram_rdata[hsct_pkg::ENTRY_W-1:hsct_pkg::KEY_W];
    assign acc_count  = rd_count + r_n;
    assign rd_empty   = (rd_key[63:48] == 16'd0);
    assign rd_match   = (rd_key == r_key);
    assign probe_last = (r_probe == t_probe'(MAX_PROBES - 1));

    // multiply-xorshift mix; stages H1 and H2 each do one multiply
    assign mix0     = r_a ^ {r_key[43:32], 20'd0} ^ r_c;
    assign mix1     = mix0 ^ (mix0 >> 16);
    assign mix2     = r_v ^ (r_v >> 15);
    assign mix3     = r_v ^ (r_v >> 16);
    assign hash_idx = t_tidx'(mix3);

    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_res     = '0;
        n_res.used_entries  = hsct_pkg::t_used'(r_used);
        n_res.dropped_total = r_lost;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_raddr = r_idx;
        case (r_state)
            S_IDLE: begin
                ram_raddr = t_tidx'(i_cmd.read_index);
                if (start) begin
                    if (i_cmd.action == hsct_pkg::ACT_CLEAR) begin
                        n_state = S_CLR;
                    end else if (i_cmd.action == hsct_pkg::ACT_READ) begin
                        n_state = S_RDX;
                    end else if (i_cmd.action == hsct_pkg::ACT_ADD
                                 && i_cmd.thread_tag != 16'd0) begin
                        n_state = S_H1;
                    end else begin
                        n_done       = 1'b1;
                        n_res.status = hsct_pkg::ST_INVALID;
                    end
                end
            end
            S_H1: begin
                n_state = S_H2;
            end
            S_H2: begin
                n_state = S_H3;
            end
            S_H3: begin
                ram_raddr = hash_idx;
                n_state   = S_CMP;
            end
            S_CMP: begin
                ram_raddr = r_idx + t_tidx'(1);
                if (rd_empty || rd_match) begin
                    ram_we             = 1'b1;
                    ram_wdata          = rd_empty ? {r_n, r_key} : {acc_count, r_key};
                    n_state            = S_IDLE;
                    n_done             = 1'b1;
                    n_res.status       = rd_empty ? hsct_pkg::ST_INSERTED
                                                  : hsct_pkg::ST_ACCUMULATED;
                    n_res.entry_index  = hsct_pkg::t_index'(r_idx);
                    n_res.entry_valid  = 1'b1;
                    n_res.entry_offset = r_key[31:0];
                    n_res.entry_module = r_key[47:32];
                    n_res.entry_thread = r_key[63:48];
                    n_res.entry_count  = rd_empty ? r_n : acc_count;
                    if (rd_empty) begin
                        n_res.used_entries = hsct_pkg::t_used'(r_used + t_cnt'(1));
                    end
                end else if (probe_last) begin
                    n_state             = S_IDLE;
                    n_done              = 1'b1;
                    n_res.status        = hsct_pkg::ST_DROPPED;
                    n_res.dropped_total = r_lost + {32'd0, r_n};
                end
            end
            S_RDX: begin
                n_state            = S_IDLE;
                n_done             = 1'b1;
                n_res.status       = hsct_pkg::ST_READ;
                n_res.entry_index  = hsct_pkg::t_index'(r_idx);
                n_res.entry_valid  = !rd_empty;
                n_res.entry_offset = rd_key[31:0];
                n_res.entry_module = rd_key[47:32];
                n_res.entry_thread = rd_key[63:48];
                n_res.entry_count  = rd_count;
            end
            S_CLR: begin
                ram_we = 1'b1;
                if (r_idx == '1) begin
                    n_state      = S_IDLE;
                    n_done       = r_clr_report;
                    n_res.status = hsct_pkg::ST_CLEARED;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_idx        <= '0;
            r_probe      <= '0;
            r_used       <= '0;
            r_lost       <= '0;
            r_clr_report <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (n_done) begin
                r_res <= n_res;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_cmd.action == hsct_pkg::ACT_CLEAR) begin
                            r_idx        <= '0;
                            r_used       <= '0;
                            r_lost       <= '0;
                            r_clr_report <= 1'b1;
                        end else if (i_cmd.action == hsct_pkg::ACT_READ) begin
                            r_idx <= t_tidx'(i_cmd.read_index);
                        end
                    end
                end
                S_H3: begin
                    r_idx   <= hash_idx;
                    r_probe <= '0;
                end
                S_CMP: begin
                    if (rd_empty) begin
                        r_used <= r_used + t_cnt'(1);
                    end else if (!rd_match) begin
                        if (probe_last) begin
                            r_lost <= r_lost + {32'd0, r_n};
                        end else begin
                            r_idx   <= r_idx + t_tidx'(1);
                            r_probe <= r_probe + t_probe'(1);
                        end
                    end
                end
                S_CLR: begin
                    r_idx <= r_idx + t_tidx'(1);
                    if (r_idx == '1) begin
                        r_clr_report <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // item capture and hash stages
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a   <= i_cmd.code_offset * hsct_pkg::HASH_OFF_MUL;
            r_c   <= {16'd0, i_cmd.thread_tag} * hsct_pkg::HASH_THR_MUL;
            r_key <= {i_cmd.thread_tag, i_cmd.module_tag, i_cmd.code_offset};
            r_n   <= i_cmd.add_count;
        end
        if (r_state == S_H1) begin
            r_v <= mix1 * hsct_pkg::MIX_MUL_A;
        end else if (r_state == S_H2) begin
            r_v <= mix2 * hsct_pkg::MIX_MUL_B;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

>>> src/hsct_checker.sv
`include "hashed_sample_count_table_defines.svh"

module hsct_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input hsct_pkg::t_cmd    i_cmd,
    input logic              o_done,
    input hsct_pkg::t_result o_result
);

    logic acc_invalid;
    logic acc_work;

    assign acc_invalid = start && !busy
        && !(i_cmd.action == hsct_pkg::ACT_CLEAR || i_cmd.action == hsct_pkg::ACT_READ
             || (i_cmd.action == hsct_pkg::ACT_ADD && i_cmd.thread_tag != 16'd0));
    assign acc_work = start && !busy && !acc_invalid;

    // rejected items are answered with o_done and an invalid status
    `HSCT_CHECK_NEXT(a_invalid_answer, acc_invalid, o_done && o_result.status == hsct_pkg::ST_INVALID, "invalid item not answered next cycle")
    // real work holds off the next item
    `HSCT_CHECK_NEXT(a_work_busy, acc_work, busy, "busy not raised after accepted item")
    // clear leaves empty totals
    `HSCT_CHECK_NOW(a_clear_totals, o_done && o_result.status == hsct_pkg::ST_CLEARED, o_result.used_entries == 13'd0 && o_result.dropped_total == 64'd0, "clear result with nonzero totals")
    // results without an entry show none
    `HSCT_CHECK_NOW(a_no_entry, o_done && (o_result.status == hsct_pkg::ST_DROPPED || o_result.status == hsct_pkg::ST_INVALID || o_result.status == hsct_pkg::ST_CLEARED), !o_result.entry_valid && o_result.entry_count == 32'd0 && o_result.entry_index == 12'd0, "entry fields set on entryless result")

endmodule

bind hashed_sample_count_table hsct_checker u_hsct_checker (.*);
